### hw/rtl/sgsc_pkg.sv
// shared types, constants and constant functions for the stereo shift gain soft clip channel
package sgsc_pkg;

  localparam int FRAC_BITS = 20;
  localparam int SAMPLE_W  = 24;
  localparam int VOL_W     = 16;
  localparam int SUM_W     = SAMPLE_W + 1;
  localparam int SCALED_W  = SUM_W + 1;
  localparam int A_W       = FRAC_BITS + 2;
  localparam int CMP_W     = ((SCALED_W > A_W) ? SCALED_W : A_W) + 1;
  localparam int MAG_W     = FRAC_BITS + 1;
  localparam int K_W       = FRAC_BITS + 2;
  localparam int PROD_W    = 2 * FRAC_BITS + 3;
  localparam int YMAG_W    = PROD_W - FRAC_BITS - 1;
  localparam int YE_W      = (YMAG_W > SAMPLE_W + 1) ? YMAG_W : SAMPLE_W + 1;
  localparam int SHIFT_W   = 6;

  localparam int MUTE_SHIFT  = 17;
  localparam int MIN_SHIFT   = -2;
  localparam int BASE_OFFSET = 3;

  localparam int unsigned VOL_NUM   = 262140;
  localparam int unsigned VOL_BASE  = 13107;
  localparam int unsigned PAN_FULL  = 65535;
  localparam int unsigned PAN_SIDE  = 16384;
  localparam int unsigned GB_MAX    = 20;
  localparam int unsigned PB_MAX    = 19;
  localparam logic [VOL_W-1:0] VOL_RESET = 16'd32768;
  localparam logic [VOL_W-1:0] PAN_RESET = 16'd32768;

  localparam longint unsigned FixDen   = 64'd10000000000000;
  localparam longint unsigned CLIP_NUM = 64'd14137166941154;
  localparam longint unsigned K_NUM    = 64'd28274333882308;

  localparam longint unsigned POS_LIM = (64'd1 << (SAMPLE_W - 1)) - 64'd1;
  localparam longint unsigned NEG_LIM = 64'd1 << (SAMPLE_W - 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic signed [A_W-1:0]      amp_t;
  typedef logic signed [SHIFT_W-1:0]  shift_t;

  typedef struct packed {
    shift_t left;
    shift_t right;
  } shift_pair_t;

  typedef enum logic [0:0] {
    REG_VOLUME = 1'b0,
    REG_PAN    = 1'b1
  } cfg_reg_t;

  // round(num / FixDen * 2^FRAC_BITS), half up
  function automatic longint unsigned to_fixed(input longint unsigned num);
    longint unsigned r;
    longint unsigned rem;
    r   = num / FixDen;
    rem = num % FixDen;
    for (int i = 0; i < FRAC_BITS + 1; i++) begin
      rem = rem * 2;
      r   = r * 2 + ((rem >= FixDen) ? 64'd1 : 64'd0);
      if (rem >= FixDen) rem = rem - FixDen;
    end
    return (r + 64'd1) >> 1;
  endfunction

  localparam longint unsigned CLIP = to_fixed(CLIP_NUM);
  localparam longint unsigned KNEE = to_fixed(K_NUM);

endpackage

### hw/rtl/stereo_shift_gain_soft_clip_channel_core.sv
// top level of the stereo shift gain soft clip channel
//
// input channel: in_valid / in_stall with sample_left and sample_right,
// one stereo pair per transaction in signed fixed point.
// output channel: out_valid / out_stall with out_left and out_right,
// one processed pair for every input transaction, in order.
// config channel: cfg_valid / cfg_ready with cfg_index and cfg_data;
// index 0 is volume, index 1 is pan_position. cfg_ready is always high.
// write config only while no transaction is in flight.
// an input pair passes the stage 1, stage 2 and output registers before
// out_valid rises; throughput is one pair per cycle while out_stall is
// low, through the three stage pipeline: input sum and shift decode,
// gain and clip, then the curve multiply and output average.
// when the receiver stalls, finished pairs stay in the output register and
// the stages behind it keep filling until all three hold a pair, then
// in_stall rises.
// rst (synchronous, active high) empties the pipeline, clears the previous
// input and curve values and sets volume and pan to mid scale.
module stereo_shift_gain_soft_clip_channel_core import sgsc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  sample_t          sample_left,
  input  sample_t          sample_right,
  output logic             out_valid,
  input  logic             out_stall,
  output sample_t          out_left,
  output sample_t          out_right,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  cfg_reg_t         cfg_index,
  input  logic [VOL_W-1:0] cfg_data
);

  logic [VOL_W-1:0] volume;
  logic [VOL_W-1:0] pan_position;
  shift_pair_t      shifts_dec;

  sample_t prev_in_left;
  sample_t prev_in_right;
  sample_t prev_shaped_left;
  sample_t prev_shaped_right;

  logic        v1;
  sum_t        sum_l;
  sum_t        sum_r;
  shift_pair_t shifts;

  logic v2;
  amp_t amp_l;
  amp_t amp_r;
  amp_t amp_l_next;
  amp_t amp_r_next;

  sample_t shaped_l;
  sample_t shaped_r;
  sum_t    avg_l;
  sum_t    avg_r;

  logic adv3;
  logic load3;
  logic rdy2;
  logic load2;
  logic accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      volume       <= VOL_RESET;
      pan_position <= PAN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_VOLUME: volume       <= cfg_data;
        REG_PAN:    pan_position <= cfg_data;
        default: ;
      endcase
    end
  end

  sgsc_shift_decode u_decode (
    .volume       (volume),
    .pan_position (pan_position),
    .shifts       (shifts_dec)
  );

  // pipeline flow
  assign adv3     = !out_valid || !out_stall;
  assign load3    = v2 && adv3;
  assign rdy2     = !v2 || adv3;
  assign load2    = v1 && rdy2;
  assign in_stall = v1 && !rdy2;
  assign accept   = in_valid && !in_stall;

  // stage 1: input average sum and decoded shifts
  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      prev_in_left  <= '0;
      prev_in_right <= '0;
    end else begin
      if (accept) begin
        v1            <= 1'b1;
        prev_in_left  <= sample_left;
        prev_in_right <= sample_right;
      end else if (load2) begin
        v1 <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sum_l  <= SUM_W'(sample_left) + SUM_W'(prev_in_left);
      sum_r  <= SUM_W'(sample_right) + SUM_W'(prev_in_right);
      shifts <= shifts_dec;
    end
  end

  // stage 2: gain and clip
  sgsc_scale_clip u_scale_l (
    .sum   (sum_l),
    .shift (shifts.left),
    .amp   (amp_l_next)
  );

  sgsc_scale_clip u_scale_r (
    .sum   (sum_r),
    .shift (shifts.right),
    .amp   (amp_r_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (load2) begin
      v2 <= 1'b1;
    end else if (load3) begin
      v2 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load2) begin
      amp_l <= amp_l_next;
      amp_r <= amp_r_next;
    end
  end

  // stage 3: curve and output average
  sgsc_shaper u_shape_l (
    .amp    (amp_l),
    .shaped (shaped_l)
  );

  sgsc_shaper u_shape_r (
    .amp    (amp_r),
    .shaped (shaped_r)
  );

  assign avg_l = SUM_W'(shaped_l) + SUM_W'(prev_shaped_left);
  assign avg_r = SUM_W'(shaped_r) + SUM_W'(prev_shaped_right);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid         <= 1'b0;
      prev_shaped_left  <= '0;
      prev_shaped_right <= '0;
    end else begin
      if (load3) begin
        out_valid         <= 1'b1;
        prev_shaped_left  <= shaped_l;
        prev_shaped_right <= shaped_r;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load3) begin
      out_left  <= avg_l[SUM_W-1:1];
      out_right <= avg_r[SUM_W-1:1];
    end
  end

  // checks
  a_empty_not_stalled: assert property (@(posedge clk) disable iff (rst)
    (!v1 && !v2 && !out_valid) |-> !in_stall)
    else $error("input stalled with an empty pipeline");

  a_amp_in_clip: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (amp_l <= $signed(A_W'(CLIP)) && amp_l >= -$signed(A_W'(CLIP)) &&
            amp_r <= $signed(A_W'(CLIP)) && amp_r >= -$signed(A_W'(CLIP))))
    else $error("clipped amplitude out of range");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    (shifts_dec.left >= SHIFT_W'(MIN_SHIFT) && shifts_dec.left <= SHIFT_W'(MUTE_SHIFT) &&
     shifts_dec.right >= SHIFT_W'(MIN_SHIFT) && shifts_dec.right <= SHIFT_W'(MUTE_SHIFT)))
    else $error("decoded shift out of range");

  a_prev_in_tracks: assert property (@(posedge clk) disable iff (rst)
    accept |=> (prev_in_left == $past(sample_left) && prev_in_right == $past(sample_right)))
    else $error("previous input not updated on transaction");

endmodule

### hw/rtl/sgsc_shift_decode.sv
// decodes volume and pan into one clamped shift per channel
module sgsc_shift_decode import sgsc_pkg::*; (
  input  logic [VOL_W-1:0] volume,
  input  logic [VOL_W-1:0] pan_position,
  output shift_pair_t      shifts
);

  logic [17:0]        den_v;
  logic [GB_MAX-1:0]  ge_v;
  logic [PB_MAX-1:0]  ge_p;
  logic [4:0]         gb;
  logic [4:0]         pb;
  logic signed [17:0] t;
  logic [15:0]        d;
  logic [15:0]        den_p;
  logic               pan_right;
  logic               pan_left;
  logic signed [6:0]  base;
  logic signed [6:0]  raw_l;
  logic signed [6:0]  raw_r;

  function automatic shift_t clamp_shift(input logic signed [6:0] s);
    if (s < 7'(MIN_SHIFT)) return SHIFT_W'(MIN_SHIFT);
    if (s > 7'(MUTE_SHIFT)) return SHIFT_W'(MUTE_SHIFT);
    return SHIFT_W'(s);
  endfunction

  assign den_v = {1'b0, volume, 1'b0} + 18'(VOL_BASE);
  assign t     = $signed({1'b0, pan_position, 1'b0}) - 18'(PAN_FULL);
  assign d     = t[17] ? 16'(-t) : 16'(t);
  assign den_p = 16'(PAN_FULL) - d;

  assign pan_right = (t >= $signed(18'(PAN_SIDE)));
  assign pan_left  = (t <= -$signed(18'(PAN_SIDE)));

  // gb >= k exactly when den_v <= floor(VOL_NUM / k)
  for (genvar k = 1; k <= GB_MAX; k++) begin : g_vol
    localparam int unsigned THR = VOL_NUM / k;
    assign ge_v[k-1] = (den_v <= 18'(THR));
  end

  // pan attenuation, saturated where the shift mutes anyway
  for (genvar k = 1; k <= PB_MAX; k++) begin : g_pan
    localparam int unsigned THR = PAN_FULL / k;
    assign ge_p[k-1] = (den_p <= 16'(THR));
  end

  always_comb begin
    gb = '0;
    pb = '0;
    for (int i = 0; i < GB_MAX; i++) gb = gb + 5'(ge_v[i]);
    for (int i = 0; i < PB_MAX; i++) pb = pb + 5'(ge_p[i]);
  end

  assign base  = $signed({2'b00, gb}) - 7'(BASE_OFFSET);
  assign raw_l = pan_right ? base + $signed({2'b00, pb}) : base;
  assign raw_r = pan_left  ? base + $signed({2'b00, pb}) : base;

  assign shifts.left  = clamp_shift(raw_l);
  assign shifts.right = clamp_shift(raw_r);

endmodule

### hw/rtl/sgsc_scale_clip.sv
// applies the power of two gain to the input average and clamps it to the clip level
module sgsc_scale_clip import sgsc_pkg::*; (
  input  sum_t   sum,
  input  shift_t shift,
  output amp_t   amp
);

  localparam logic signed [CMP_W-1:0] CLIP_POS = CMP_W'(CLIP);
  localparam logic signed [CMP_W-1:0] CLIP_NEG = -CMP_W'(CLIP);

  logic signed [SCALED_W-1:0] sum_ext;
  logic signed [SCALED_W-1:0] scaled;
  logic signed [CMP_W-1:0]    wide;
  logic signed [CMP_W-1:0]    clamped;
  logic [4:0]                 sh_amt;

  assign sum_ext = SCALED_W'(sum);
  assign sh_amt  = 5'(shift + SHIFT_W'(1));

  always_comb begin
    if (shift >= SHIFT_W'(MUTE_SHIFT)) begin
      scaled = '0;
    end else if (shift == SHIFT_W'(MIN_SHIFT)) begin
      scaled = sum_ext <<< 1;
    end else if (shift == SHIFT_W'(-1)) begin
      scaled = sum_ext;
    end else begin
      scaled = sum_ext >>> sh_amt;
    end
  end

  assign wide = CMP_W'(scaled);

  always_comb begin
    if (wide > CLIP_POS) begin
      clamped = CLIP_POS;
    end else if (wide < CLIP_NEG) begin
      clamped = CLIP_NEG;
    end else begin
      clamped = wide;
    end
  end

  assign amp = A_W'(clamped);

endmodule

### hw/rtl/sgsc_shaper.sv
// soft clip curve y = a*(k-|a|)/2 with the magnitude rounded half up and saturation to the sample range
module sgsc_shaper import sgsc_pkg::*; (
  input  amp_t    amp,
  output sample_t shaped
);

  logic                     neg;
  logic [MAG_W-1:0]         mag;
  logic [K_W-1:0]           diff;
  logic [PROD_W-1:0]        prod;
  logic [YMAG_W-1:0]        ymag;
  logic [YE_W-1:0]          ye;
  logic [YE_W-1:0]          lim;
  logic [YE_W-1:0]          sel;
  logic [YE_W-1:0]          yw;

  assign neg  = amp[A_W-1];
  assign mag  = neg ? MAG_W'(-amp) : MAG_W'(amp);
  assign diff = K_W'(KNEE) - K_W'(mag);
  assign prod = PROD_W'(mag) * PROD_W'(diff) + (PROD_W'(1) << FRAC_BITS);
  assign ymag = prod[PROD_W-1:FRAC_BITS+1];
  assign ye   = YE_W'(ymag);
  assign lim  = neg ? YE_W'(NEG_LIM) : YE_W'(POS_LIM);
  assign sel  = (ye > lim) ? lim : ye;
  assign yw   = neg ? -sel : sel;

  assign shaped = SAMPLE_W'(yw);

endmodule
